// ===== rtl/ils_pkg.sv =====
package ils_pkg;

  // Default list capacity
  localparam int CAPACITY_DEFAULT = 16;

  // Field widths
  localparam int TYPE_W   = 2;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int FPOS_W   = 4;
  localparam int COUNT_W  = 5;

  // Stream widths, packed from bit 0 and padded to whole bytes
  localparam int IN_TDATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = STATUS_W + 1 + FPOS_W + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Request kinds
  localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_FIND   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic                load_req;    // capture incoming request
    logic                k_from_cnt;  // index <= count
    logic                k_from_pos;  // index <= position
    logic                k_clear;     // index <= 0
    logic                k_dec;
    logic                k_inc;
    logic                rd_ins;      // read entry index-1
    logic                rd_rem;      // read entry index+1
    logic                rd_fnd;      // read entry index
    logic                wr_shift;    // entry[index] <= read data
    logic                wr_value;    // entry[position] <= value
    logic                cnt_inc;
    logic                cnt_dec;
    logic                res_load;    // load result register
    logic [STATUS_W-1:0] res_status;
    logic                res_found;
  } ils_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic              ins_bad;   // position > count
    logic              rem_bad;   // position >= count
    logic              is_full;   // count == capacity
    logic              ins_more;  // index > position
    logic              rem_more;  // index + 1 < count
    logic              fnd_more;  // index < count
    logic              match;     // read data equals value
  } ils_sts_t;

endpackage

// ===== rtl/ils_datapath.sv =====
module ils_datapath #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ils_pkg::ils_cmd_t                    cmd,
  output ils_pkg::ils_sts_t                    sts,
  input  logic [ils_pkg::TYPE_W-1:0]           req_type_in,
  input  logic [ils_pkg::POS_W-1:0]            position_in,
  input  logic signed [ils_pkg::VAL_W-1:0]     value_in,
  output logic [ils_pkg::STATUS_W-1:0]         status,
  output logic                                 found,
  output logic [ils_pkg::FPOS_W-1:0]           found_position,
  output logic [ils_pkg::COUNT_W-1:0]          count
);
  import ils_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [VAL_W-1:0]        mem [CAPACITY];
  logic [TYPE_W-1:0]       req_type;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           k;
  logic [VAL_W-1:0]        rdata;

  logic [PW-1:0]    pos_ext;
  logic [PW-1:0]    cnt_ext;
  logic [PW-1:0]    k_ext;
  logic [CW-1:0]    k_m1;
  logic [CW-1:0]    k_p1;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;

  // Widened operands for compares
  assign pos_ext = PW'(position);
  assign cnt_ext = PW'(cnt);
  assign k_ext   = PW'(k);
  assign k_m1    = k - CW'(1);
  assign k_p1    = k + CW'(1);

  // Status back to the controller
  always_comb begin
    sts.req_type = req_type;
    sts.ins_bad  = pos_ext > cnt_ext;
    sts.rem_bad  = pos_ext >= cnt_ext;
    sts.is_full  = cnt == CW'(CAPACITY);
    sts.ins_more = k_ext > pos_ext;
    sts.rem_more = (k_ext + PW'(1)) < cnt_ext;
    sts.fnd_more = k < cnt;
    sts.match    = rdata == value;
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type <= req_type_in;
      position <= position_in;
      value    <= value_in;
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CW'(1);
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - CW'(1);
    end
  end

  // Walking index
  always_ff @(posedge clk) begin
    if (cmd.k_from_cnt) begin
      k <= cnt;
    end else if (cmd.k_from_pos) begin
      k <= pos_ext[CW-1:0];
    end else if (cmd.k_clear) begin
      k <= '0;
    end else if (cmd.k_dec) begin
      k <= k_m1;
    end else if (cmd.k_inc) begin
      k <= k_p1;
    end
  end

  // Memory port selection
  always_comb begin
    rd_en   = cmd.rd_ins | cmd.rd_rem | cmd.rd_fnd;
    rd_addr = k[AW-1:0];
    if (cmd.rd_ins) begin
      rd_addr = k_m1[AW-1:0];
    end else if (cmd.rd_rem) begin
      rd_addr = k_p1[AW-1:0];
    end
    wr_en   = cmd.wr_shift | cmd.wr_value;
    wr_addr = k[AW-1:0];
    wr_data = rdata;
    if (cmd.wr_value) begin
      wr_addr = pos_ext[AW-1:0];
      wr_data = value;
    end
  end

  // Entry store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status         <= cmd.res_status;
      found          <= cmd.res_found;
      found_position <= cmd.res_found ? k_ext[FPOS_W-1:0] : '0;
      count          <= cnt_ext[COUNT_W-1:0];
    end
  end

endmodule

// ===== rtl/ils_ctrl.sv =====
module ils_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  ils_pkg::ils_sts_t sts,
  output ils_pkg::ils_cmd_t cmd
);
  import ils_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DEC     = 4'd1;
  localparam logic [3:0] S_INS_CHK = 4'd2;
  localparam logic [3:0] S_INS_WR  = 4'd3;
  localparam logic [3:0] S_REM_CHK = 4'd4;
  localparam logic [3:0] S_REM_WR  = 4'd5;
  localparam logic [3:0] S_FND_CHK = 4'd6;
  localparam logic [3:0] S_FND_CMP = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [STATUS_W-1:0] res_status;
  logic [STATUS_W-1:0] res_status_next;
  logic                res_found;
  logic                res_found_next;
  logic                out_free;

  // Result slot is free or being emptied this cycle
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == S_IDLE;

  // Next state and commands
  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_found_next  = res_found;
    cmd             = '0;
    cmd.res_status  = res_status;
    cmd.res_found   = res_found;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DEC;
        end
      end
      S_DEC: begin
        res_status_next = ST_DONE;
        res_found_next  = 1'b0;
        unique case (sts.req_type)
          REQ_INSERT: begin
            if (sts.ins_bad) begin
              res_status_next = ST_BADPOS;
              state_next      = S_FIN;
            end else if (sts.is_full) begin
              res_status_next = ST_FULL;
              state_next      = S_FIN;
            end else begin
              cmd.k_from_cnt = 1'b1;
              state_next     = S_INS_CHK;
            end
          end
          REQ_REMOVE: begin
            if (sts.rem_bad) begin
              res_status_next = ST_BADPOS;
              state_next      = S_FIN;
            end else begin
              cmd.k_from_pos = 1'b1;
              state_next     = S_REM_CHK;
            end
          end
          REQ_FIND: begin
            cmd.k_clear = 1'b1;
            state_next  = S_FND_CHK;
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      // Insert: move entries up from the tail, then drop the value in
      S_INS_CHK: begin
        if (sts.ins_more) begin
          cmd.rd_ins = 1'b1;
          state_next = S_INS_WR;
        end else begin
          cmd.wr_value = 1'b1;
          cmd.cnt_inc  = 1'b1;
          state_next   = S_FIN;
        end
      end
      S_INS_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.k_dec    = 1'b1;
        state_next   = S_INS_CHK;
      end
      // Remove: move entries down from the hole towards the tail
      S_REM_CHK: begin
        if (sts.rem_more) begin
          cmd.rd_rem = 1'b1;
          state_next = S_REM_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FIN;
        end
      end
      S_REM_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.k_inc    = 1'b1;
        state_next   = S_REM_CHK;
      end
      // Find: scan from the front, stop at first hit
      S_FND_CHK: begin
        if (sts.fnd_more) begin
          cmd.rd_fnd = 1'b1;
          state_next = S_FND_CMP;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FND_CMP: begin
        if (sts.match) begin
          res_found_next = 1'b1;
          state_next     = S_FIN;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_FND_CHK;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_DONE;
      res_found  <= 1'b0;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_found  <= res_found_next;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== rtl/indexed_list_store.sv =====
// Channel   Dir  Fields (from bit 0)
// s_axis    in   tuser: req_type[1:0]; tdata: position[4:0], value[36:5]
// m_axis    out  tdata: status[1:0], found[2], found_position[6:3], count[11:7]
//
// One request at a time through an entry store with one read and one write port. A shift
// reads one entry and then writes it one place along; a find reads one entry and then
// compares it with the value, stopping at the first match.
// Reset clears the count and control; the entry store is not cleared.
// A new request is taken while an earlier result still waits on m_tready; the
// finished result then waits for the output register to empty.
module indexed_list_store #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ils_pkg::IN_TDATA_W-1:0]      s_tdata,   // position, value
  input  logic [ils_pkg::TYPE_W-1:0]          s_tuser,   // req_type
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ils_pkg::OUT_TDATA_W-1:0]     m_tdata    // status, found, found_position, count
);
  import ils_pkg::*;

  ils_cmd_t             cmd;
  ils_sts_t             sts;
  logic [STATUS_W-1:0]  status;
  logic                 found;
  logic [FPOS_W-1:0]    found_position;
  logic [COUNT_W-1:0]   count;

  ils_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ils_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_type_in    (s_tuser),
    .position_in    (s_tdata[POS_W-1:0]),
    .value_in       (s_tdata[POS_W+VAL_W-1:POS_W]),
    .status         (status),
    .found          (found),
    .found_position (found_position),
    .count          (count)
  );

  // Pack result
  assign m_tdata = {{OUT_PAD_W{1'b0}}, count, found_position, found, status};

  // Only one write source into the store per cycle
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_shift && cmd.wr_value))
    else $error("shift and value write together");

  // One request in flight
  a_single_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // Result never overwrites one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over pending result");

  // A loaded result is offered next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> m_tvalid)
    else $error("loaded result not offered");

endmodule
